FILE: hw/rtl/bsg_pkg.sv
package bsg_pkg;

  localparam int DEFAULT_MAX_WIDTH = 2048;

  localparam int PIX_W  = 8;
  localparam int T_W    = 9;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 11;
  localparam int IMGW_W = 12;
  localparam int LIM_W  = 8;
  localparam int GAIN_W = 8;
  localparam int PROD_W = T_W + GAIN_W;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLAMP_LIMIT  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN         = 2'd3;

  localparam logic [IMGW_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [ROW_W-1:0]  RST_IMAGE_HEIGHT = 16'd480;
  localparam logic [LIM_W-1:0]  RST_CLAMP_LIMIT  = 8'd8;
  localparam logic [GAIN_W-1:0] RST_GAIN         = 8'd4;

  localparam logic [PIX_W-1:0] SAT_MAX = 8'hFF;

  // b - a, capped at +lim, offset by lim, floored at zero: 0 .. 2*lim
  function automatic logic [T_W-1:0] offset_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic [LIM_W-1:0] lim);
    logic signed [10:0] d;
    logic signed [10:0] s;
    logic signed [10:0] t;
    d = $signed({3'b000, b}) - $signed({3'b000, a});
    s = $signed({3'b000, lim});
    if (d > s) begin
      d = s;
    end
    t = s + d;
    if (t < 0) begin
      t = '0;
    end
    return t[T_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] sat8(input logic [PROD_W-1:0] p);
    return (|p[PROD_W-1:PIX_W]) ? SAT_MAX : p[PIX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/boosted_saturated_gradient_unit.sv
// Pipeline: stage 1 (line-store read), stage 2 (offset differences), output register.
// Throughput: one pixel per cycle while the output is not stalled; on the last row
//   each pixel yields two result transactions through the single output register,
//   so input is held until the second transaction of each pixel is taken.
// Reset (rst_n, synchronous, active low): counters, pipeline and config return
//   to defaults; line stores are not cleared and no init pass runs.
module boosted_saturated_gradient_unit
  import bsg_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // [7:0] grad_x, [15:8] grad_y,
                                            // [31:16] out_row, [42:32] out_col
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > IMGW_W) ? WW : IMGW_W;

  // config
  logic [IMGW_W-1:0] cfg_width_r;
  logic [ROW_W-1:0]  cfg_height_r;
  logic [LIM_W-1:0]  cfg_limit_r;
  logic [GAIN_W-1:0] cfg_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_IMAGE_WIDTH;
      cfg_height_r <= RST_IMAGE_HEIGHT;
      cfg_limit_r  <= RST_CLAMP_LIMIT;
      cfg_gain_r   <= RST_GAIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata[IMGW_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata[ROW_W-1:0];
        CFG_CLAMP_LIMIT:  cfg_limit_r  <= cfg_wdata[LIM_W-1:0];
        CFG_GAIN:         cfg_gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic accept;
  logic out_valid_r;
  logic out_dual_r;
  logic out_beat_r;

  assign en        = !out_valid_r || (out_tready && (!out_dual_r || out_beat_r));
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  // position
  logic [AW-1:0]    col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [XW-1:0]    w_ext;
  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [AW-1:0]    c;
  logic [ROW_W-1:0] r;
  logic             last_col;
  logic             last_row;
  logic             interior;

  always_comb begin
    w_ext = XW'(cfg_width_r);
    if (w_ext < XW'(2)) begin
      w_ext = XW'(2);
    end else if (w_ext > XW'(MAX_WIDTH)) begin
      w_ext = XW'(MAX_WIDTH);
    end
    w_eff = WW'(w_ext);
    h_eff = (cfg_height_r < ROW_W'(2)) ? ROW_W'(2) : cfg_height_r;
    c = (WW'(col_count_r) >= w_eff) ? AW'(w_eff - WW'(1)) : col_count_r;
    r = (row_count_r >= h_eff) ? (h_eff - ROW_W'(1)) : row_count_r;
    last_col = (WW'(c) == (w_eff - WW'(1)));
    last_row = (r == (h_eff - ROW_W'(1)));
    interior = (r >= ROW_W'(2)) && (c != '0) && !last_col;
    if (last_col) begin
      col_count_nxt = '0;
      row_count_nxt = last_row ? '0 : (r + ROW_W'(1));
    end else begin
      col_count_nxt = c + AW'(1);
      row_count_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (accept) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // line stores: A holds {older, prev} at column c, B holds prev read at c+1
  logic                s1_valid_r;
  logic [PIX_W-1:0]    s1_px_r;
  logic [AW-1:0]       s1_c_r;
  logic [ROW_W-1:0]    s1_orow_r;
  logic                s1_has_out_r;
  logic                s1_interior_r;
  logic                s1_dual_r;
  logic                s1_fwd_a_r;
  logic [2*PIX_W-1:0]  s1_fwd_a_data_r;
  logic                s1_fwd_b_r;
  logic [PIX_W-1:0]    s1_fwd_b_data_r;

  logic [2*PIX_W-1:0]  ram_a_rdata;
  logic [PIX_W-1:0]    ram_b_rdata;
  logic [2*PIX_W-1:0]  a_sel;
  logic [PIX_W-1:0]    prev_c;
  logic [PIX_W-1:0]    older_c;
  logic [PIX_W-1:0]    right_px;
  logic [AW-1:0]       raddr_b;
  logic                wr_en;
  logic [PIX_W-1:0]    left_r;

  assign a_sel    = s1_fwd_a_r ? s1_fwd_a_data_r : ram_a_rdata;
  assign prev_c   = a_sel[PIX_W-1:0];
  assign older_c  = a_sel[2*PIX_W-1:PIX_W];
  assign right_px = s1_fwd_b_r ? s1_fwd_b_data_r : ram_b_rdata;
  assign raddr_b  = c + AW'(1);
  assign wr_en    = s1_valid_r && en;

  bsg_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_c_r),
    .wdata ({prev_c, s1_px_r}),
    .re    (accept),
    .raddr (c),
    .rdata (ram_a_rdata)
  );

  bsg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_c_r),
    .wdata (s1_px_r),
    .re    (accept),
    .raddr (raddr_b),
    .rdata (ram_b_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r         <= in_tdata[PIX_W-1:0];
      s1_c_r          <= c;
      s1_orow_r       <= r - ROW_W'(1);
      s1_has_out_r    <= (r != '0);
      s1_interior_r   <= interior;
      s1_dual_r       <= last_row;
      s1_fwd_a_r      <= s1_valid_r && (s1_c_r == c);
      s1_fwd_a_data_r <= {prev_c, s1_px_r};
      s1_fwd_b_r      <= s1_valid_r && (s1_c_r == raddr_b);
      s1_fwd_b_data_r <= s1_px_r;
    end
    if (wr_en) begin
      left_r <= prev_c;
    end
  end

  // offset differences
  logic             s2_valid_r;
  logic [T_W-1:0]   s2_tx_r;
  logic [T_W-1:0]   s2_ty_r;
  logic [ROW_W-1:0] s2_orow_r;
  logic [AW-1:0]    s2_c_r;
  logic             s2_dual_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r && s1_has_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tx_r   <= s1_interior_r ? offset_diff(left_r, right_px, cfg_limit_r) : '0;
      s2_ty_r   <= s1_interior_r ? offset_diff(older_c, s1_px_r, cfg_limit_r) : '0;
      s2_orow_r <= s1_orow_r;
      s2_c_r    <= s1_c_r;
      s2_dual_r <= s1_dual_r;
    end
  end

  // gain and saturation into the output register
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [PIX_W-1:0]  out_gx_r;
  logic [PIX_W-1:0]  out_gy_r;
  logic [ROW_W-1:0]  out_orow_r;
  logic [AW-1:0]     out_c_r;

  assign prod_x = PROD_W'(s2_tx_r) * PROD_W'(cfg_gain_r);
  assign prod_y = PROD_W'(s2_ty_r) * PROD_W'(cfg_gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_dual_r  <= 1'b0;
      out_beat_r  <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid_r;
      out_dual_r  <= s2_dual_r;
      out_beat_r  <= 1'b0;
    end else if (out_tready) begin
      out_beat_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_gx_r   <= sat8(prod_x);
      out_gy_r   <= sat8(prod_y);
      out_orow_r <= s2_orow_r;
      out_c_r    <= s2_c_r;
    end
  end

  // second transaction of a last-row pixel: zero gradients on the last row
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0,
                       COL_W'(out_c_r),
                       out_beat_r ? (out_orow_r + ROW_W'(1)) : out_orow_r,
                       out_beat_r ? '0 : out_gy_r,
                       out_beat_r ? '0 : out_gx_r};

`ifndef SYNTHESIS
  a_beat_needs_dual: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat_r |-> (out_valid_r && out_dual_r))
    else $error("second beat without a dual result");

  a_beat_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_beat_r) |-> $past(out_tvalid && out_tready))
    else $error("second beat started without a first transaction");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while result stalled");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_col) |=> (col_count_r == '0))
    else $error("column count did not wrap at row end");
`endif

endmodule

FILE: hw/rtl/bsg_ram.sv
module bsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
